### src/twcg_pkg.sv
package twcg_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int NUM_CHANNELS = 64;
  localparam int TIME_BITS    = 48;

  localparam int ENERGY_BITS  = 32;
  localparam int CHAN_BITS    = 6;
  localparam int GROUP_BITS   = 32;
  localparam int MAJ_BITS     = 5;
  localparam int CFG_BITS     = 64;
  localparam int CFG_IDX_BITS = 2;

  localparam int IDX_BITS = $clog2(WINDOW_DEPTH);
  localparam int CNT_BITS = $clog2(WINDOW_DEPTH + 1);

  localparam int IN_FIELD_BITS  = TIME_BITS + ENERGY_BITS + CHAN_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = TIME_BITS + ENERGY_BITS + CHAN_BITS + GROUP_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAJORITY      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHAN_MASK     = 2'd2;

  localparam logic [MAJ_BITS-1:0] MAJORITY_RESET = 5'd2;

  typedef struct packed {
    logic [TIME_BITS-1:0]   hit_time;
    logic [ENERGY_BITS-1:0] hit_energy;
    logic [CHAN_BITS-1:0]   hit_channel;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic append;
    logic drop_append;
    logic refresh;
    logic rd_emit;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic hit_enabled;
    logic store_empty;
    logic in_window;
    logic majority_met;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

### src/twcg_ctrl.sv
module twcg_ctrl import twcg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EVAL    = 5'b00010,
    S_REFRESH = 5'b00100,
    S_EMIT_RD = 5'b01000,
    S_EMIT_WR = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!status.hit_enabled) begin
          state_next = S_IDLE;
        end else if (status.store_empty || status.in_window) begin
          cmd.append = 1'b1;
          state_next = S_IDLE;
        end else if (status.majority_met) begin
          state_next = S_EMIT_RD;
        end else begin
          cmd.drop_append = 1'b1;
          state_next      = S_REFRESH;
        end
      end
      S_REFRESH: begin
        cmd.refresh = 1'b1;
        state_next  = S_IDLE;
      end
      S_EMIT_RD: begin
        cmd.rd_emit = 1'b1;
        state_next  = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        cmd.rd_emit = 1'b1;
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          state_next    = status.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/twcg_dp.sv
module twcg_dp import twcg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_data,
  input  entry_t                   in_entry,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  logic                     out_ready,
  output logic                     out_valid,
  output entry_t                   out_entry,
  output logic [GROUP_BITS-1:0]    out_group,
  output logic                     out_last,
  output logic                     out_overflow
);

  logic [TIME_BITS-1:0]    window_length;
  logic [MAJ_BITS-1:0]     majority_count;
  logic [NUM_CHANNELS-1:0] channel_enable_mask;

  entry_t                  hit;
  logic [IDX_BITS-1:0]     oldest_index;
  logic [CNT_BITS-1:0]     stored_count;
  logic [GROUP_BITS-1:0]   group_counter;
  logic                    overflow_flag;
  logic [TIME_BITS-1:0]    oldest_time;
  logic [IDX_BITS-1:0]     emit_idx;
  logic                    refresh_bypass;

  entry_t                  store [WINDOW_DEPTH];
  entry_t                  rd_data;
  logic [IDX_BITS-1:0]     rd_addr;
  logic [IDX_BITS-1:0]     wr_addr;
  logic                    wr_en;
  logic [TIME_BITS-1:0]    time_diff;
  logic                    store_full;

  function automatic logic [IDX_BITS-1:0] slot_of(input logic [IDX_BITS-1:0] base,
                                                  input logic [CNT_BITS-1:0] offset);
    logic [CNT_BITS:0] s;
    s = {{(CNT_BITS + 1 - IDX_BITS){1'b0}}, base} + {1'b0, offset};
    if (s >= (CNT_BITS + 1)'(WINDOW_DEPTH)) begin
      s = s - (CNT_BITS + 1)'(WINDOW_DEPTH);
    end
    return s[IDX_BITS-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length       <= '0;
      majority_count      <= MAJORITY_RESET;
      channel_enable_mask <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH: window_length       <= cfg_data[TIME_BITS-1:0];
        CFG_MAJORITY:      majority_count      <= cfg_data[MAJ_BITS-1:0];
        CFG_CHAN_MASK:     channel_enable_mask <= cfg_data[NUM_CHANNELS-1:0];
        default: ;
      endcase
    end
  end

  assign store_full = (stored_count == CNT_BITS'(WINDOW_DEPTH));
  assign time_diff  = hit.hit_time - oldest_time;

  always_comb begin
    status.hit_enabled  = ({1'b0, hit.hit_channel} < (CHAN_BITS + 1)'(NUM_CHANNELS)) &&
                          channel_enable_mask[hit.hit_channel[$clog2(NUM_CHANNELS > 1 ?
                          NUM_CHANNELS : 2)-1:0]];
    status.store_empty  = (stored_count == '0);
    status.in_window    = (hit.hit_time < oldest_time) || (time_diff <= window_length);
    status.majority_met = (int'(majority_count) <= int'(stored_count));
    status.emit_last    = ({1'b0, emit_idx} + CNT_BITS'(1)) == stored_count;
    status.out_free     = !out_valid || out_ready;
  end

  // store port addresses
  assign wr_addr = slot_of(oldest_index, stored_count);
  assign wr_en   = (cmd.append && !store_full) || cmd.drop_append;
  assign rd_addr = cmd.rd_emit ? slot_of(oldest_index, {1'b0, emit_idx})
                               : slot_of(oldest_index, CNT_BITS'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= hit;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      hit <= in_entry;
    end
  end

  // window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_index   <= '0;
      stored_count   <= '0;
      group_counter  <= '0;
      overflow_flag  <= 1'b0;
      emit_idx       <= '0;
      refresh_bypass <= 1'b0;
    end else begin
      if (cmd.append) begin
        if (store_full) begin
          overflow_flag <= 1'b1;
        end else begin
          stored_count <= stored_count + CNT_BITS'(1);
        end
      end
      if (cmd.drop_append) begin
        oldest_index   <= slot_of(oldest_index, CNT_BITS'(1));
        refresh_bypass <= (stored_count == CNT_BITS'(1));
      end
      if (cmd.emit_load) begin
        if (status.emit_last) begin
          emit_idx      <= '0;
          stored_count  <= '0;
          oldest_index  <= '0;
          group_counter <= group_counter + GROUP_BITS'(1);
        end else begin
          emit_idx <= emit_idx + IDX_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && (stored_count == '0)) begin
      oldest_time <= hit.hit_time;
    end else if (cmd.refresh) begin
      oldest_time <= refresh_bypass ? hit.hit_time : rd_data.hit_time;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_entry    <= rd_data;
      out_group    <= group_counter;
      out_last     <= status.emit_last;
      out_overflow <= overflow_flag;
    end
  end

endmodule

### src/time_window_coincidence_grouper_core.sv
// Coincidence grouper for a stream of detector hits.
// s_axis carries one hit per word; hits on disabled channels are dropped.
// The block keeps a window of up to WINDOW_DEPTH hits measured from the
// oldest stored hit. A hit outside the window either closes a group (when
// the stored count reaches majority_count) or pushes out the oldest hit.
// A closed group leaves on m_axis oldest first, one word per stored hit,
// tagged with the group number; tlast marks the final word of a group and
// tuser carries the sticky overflow flag. The closing hit is discarded.
// Configuration is written through cfg_we / cfg_index / cfg_data; the
// user must write it only while idle, which the block does not enforce.
// Timing: a hit is evaluated in the cycle after it is taken; a hit that
// replaces the oldest adds a read of the hit store to find the new oldest
// time. A closing hit leaves one word at a time through the single store
// read port, each word waiting for the output register to be free.
// Results sit in an output register, so a new hit is accepted while the
// last word waits; if the receiver stalls, emission of a further group
// waits for that register. Reset empties the window, clears the group
// number and overflow flag and restores the configuration defaults.
module time_window_coincidence_grouper_core import twcg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_data,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // hit_time, hit_energy, hit_channel
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // out_time, out_energy, out_channel, group_number
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic                     m_axis_tlast,
  // overflow_seen
  output logic                     m_axis_tuser
);

  cmd_t                  cmd;
  status_t               status;
  entry_t                in_entry;
  entry_t                out_entry;
  logic [GROUP_BITS-1:0] out_group;

  assign in_entry.hit_time    = s_axis_tdata[TIME_BITS-1:0];
  assign in_entry.hit_energy  = s_axis_tdata[TIME_BITS +: ENERGY_BITS];
  assign in_entry.hit_channel = s_axis_tdata[TIME_BITS + ENERGY_BITS +: CHAN_BITS];

  twcg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  twcg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_entry     (in_entry),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_entry    (out_entry),
    .out_group    (out_group),
    .out_last     (m_axis_tlast),
    .out_overflow (m_axis_tuser)
  );

  assign m_axis_tdata = {{(OUT_DATA_BITS - OUT_FIELD_BITS){1'b0}}, out_group,
                         out_entry.hit_channel, out_entry.hit_energy, out_entry.hit_time};

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> status.out_free)
    else $error("output word overwritten before it was taken");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.append, cmd.drop_append, cmd.refresh, cmd.emit_load}))
    else $error("more than one store action in a cycle");

  a_eval_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("hit accepted while previous hit still under evaluation");

  a_idle_after_group: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load && status.emit_last) |=> s_axis_tready)
    else $error("not ready after the last word of a group");

endmodule

### verif/time_window_coincidence_grouper_core_tb.sv
module time_window_coincidence_grouper_core_tb;
  import twcg_pkg::*;

  localparam int SETTLE_CYCLES    = 40;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASES           = 6;
  localparam int HITS_PER_PHASE   = 28;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
  localparam logic [TIME_BITS-1:0]    TIME_MAX  = '1;
  localparam logic [CHAN_BITS-1:0]    CHAN_MAX  = '1;

  typedef enum logic {ROW_HIT, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]   t;
    logic [ENERGY_BITS-1:0] e;
    logic [CHAN_BITS-1:0]   ch;
    logic [GROUP_BITS-1:0]  grp;
    logic                   last;
    logic                   ovf;
  } grouped_word_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [CFG_BITS-1:0]     value;
    entry_t                  hit;
    int                      reps;
    bit                      typed;
    grouped_word_t           word;
  } stim_row_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_BITS-1:0]      cfg_data;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  // hit_time, hit_energy, hit_channel
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  // out_time, out_energy, out_channel, group_number
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tlast;
  // overflow_seen
  logic                     m_axis_tuser;

  time_window_coincidence_grouper_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  entry_t                win_store [WINDOW_DEPTH];
  int                    win_head;
  int                    win_fill;
  logic [GROUP_BITS-1:0] next_group;
  logic                  ovf_sticky;
  logic [TIME_BITS-1:0]  cfg_window;
  logic [MAJ_BITS-1:0]   cfg_majority;
  logic [CFG_BITS-1:0]   cfg_mask;
  grouped_word_t         grouped_words[$];
  stim_row_t             dir_rows[$];
  int                    errors;
  int                    tx_gap_pct;
  int                    rx_stall_pct;
  bit                    calm;
  bit                    long_hold;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  function automatic void store_hit(entry_t h);
    if (win_fill >= WINDOW_DEPTH) begin
      ovf_sticky = 1'b1;
    end else begin
      win_store[(win_head + win_fill) % WINDOW_DEPTH] = h;
      win_fill++;
    end
  endfunction

  function automatic void predict_group(entry_t h);
    logic [TIME_BITS-1:0] oldest;
    grouped_word_t w;
    entry_t s;
    if (!cfg_mask[h.hit_channel]) return;
    if (win_fill == 0) begin
      store_hit(h);
      return;
    end
    oldest = win_store[win_head].hit_time;
    if (h.hit_time < oldest || (h.hit_time - oldest) <= cfg_window) begin
      store_hit(h);
    end else if (win_fill >= int'(cfg_majority)) begin
      for (int i = 0; i < win_fill; i++) begin
        s = win_store[(win_head + i) % WINDOW_DEPTH];
        w.t = s.hit_time;
        w.e = s.hit_energy;
        w.ch = s.hit_channel;
        w.grp = next_group;
        w.last = (i == win_fill - 1);
        w.ovf = ovf_sticky;
        grouped_words = {grouped_words, w};
      end
      win_fill = 0;
      win_head = 0;
      next_group++;
    end else begin
      win_head = (win_head + 1) % WINDOW_DEPTH;
      win_fill--;
      store_hit(h);
    end
  endfunction

  function automatic void apply_config(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
    case (idx)
      CFG_WINDOW_LENGTH: cfg_window = v[TIME_BITS-1:0];
      CFG_MAJORITY:      cfg_majority = v[MAJ_BITS-1:0];
      CFG_CHAN_MASK:     cfg_mask = v;
      default: ;
    endcase
  endfunction

  function automatic void add_hit(logic [TIME_BITS-1:0] t, logic [ENERGY_BITS-1:0] e,
                                  logic [CHAN_BITS-1:0] ch, int reps = 1, bit typed = 1'b0,
                                  grouped_word_t word = '0);
    stim_row_t r;
    r.kind = ROW_HIT;
    r.idx = CFG_WINDOW_LENGTH;
    r.value = '0;
    r.hit.hit_time = t;
    r.hit.hit_energy = e;
    r.hit.hit_channel = ch;
    r.reps = reps;
    r.typed = typed;
    r.word = word;
    dir_rows = {dir_rows, r};
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.value = v;
    r.hit = '0;
    r.reps = 0;
    r.typed = 1'b0;
    r.word = '0;
    dir_rows = {dir_rows, r};
  endfunction

  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
    end
  endtask

  task automatic send_hit(entry_t h, bit typed, grouped_word_t word);
    int n0;
    if (!calm && $urandom_range(0, 99) < tx_gap_pct) idle_sender($urandom_range(1, 12));
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = IN_DATA_BITS'({h.hit_channel, h.hit_energy, h.hit_time});
    do @(posedge clk); while (!s_axis_tready);
    n0 = grouped_words.size();
    predict_group(h);
    if (typed) begin
      while (grouped_words.size() > n0) void'(grouped_words.pop_back());
      grouped_words = {grouped_words, word};
    end
  endtask

  task automatic wait_results();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (grouped_words.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(posedge clk);
    apply_config(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_phase(int p);
    logic [TIME_BITS-1:0] t;
    logic [CFG_BITS-1:0]  w;
    logic [CFG_BITS-1:0]  m;
    logic [CFG_BITS-1:0]  mask;
    entry_t h;
    int taken;
    int pick;
    int reach;
    settle();
    w = CFG_BITS'($urandom_range(1, 60));
    m = CFG_BITS'($urandom_range(1, 4));
    mask = '1;
    tx_gap_pct = $urandom_range(0, 2) * 20;
    rx_stall_pct = $urandom_range(0, 2) * 20;
    case (p)
      1: begin
        w = CFG_BITS'($urandom_range(0, 20));
        m = CFG_BITS'(1);
        tx_gap_pct = 0;
      end
      2: begin
        m = CFG_BITS'($urandom_range(2, 5));
        mask = {$urandom, $urandom};
      end
      3: begin
        w = {$urandom_range(0, 255), $urandom};
        m = '0;
        mask = {$urandom, $urandom};
      end
      4: begin
        w = CFG_BITS'($urandom_range(0, 60));
        m = CFG_BITS'($urandom_range(17, 31));
      end
      5: begin
        w = CFG_BITS'($urandom_range(0, 60));
        m = CFG_BITS'($urandom_range(1, 3));
      end
      default: ;
    endcase
    write_cfg(CFG_WINDOW_LENGTH, w);
    write_cfg(CFG_MAJORITY, m);
    write_cfg(CFG_CHAN_MASK, mask);
    if (p == 1) long_hold = 1'b1;
    if (p == PHASES - 1) calm = 1'b1;
    reach = (cfg_window > 1000) ? 1000 : int'(cfg_window);
    t = TIME_BITS'({$urandom, $urandom});
    taken = 0;
    while (taken < HITS_PER_PHASE) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        t = t + $urandom_range(0, reach);
      end else if (pick < 92) begin
        t = t + cfg_window + 1 + $urandom_range(0, 20);
      end else begin
        t = t - $urandom_range(1, 30);
      end
      h.hit_time = t;
      h.hit_energy = $urandom;
      h.hit_channel = CHAN_BITS'($urandom_range(0, 63));
      send_hit(h, 1'b0, '0);
      if (cfg_mask[h.hit_channel]) begin
        taken++;
        // sender stops until the block has emptied its output
        if (p == 3 && taken == HITS_PER_PHASE / 2) wait_results();
      end
    end
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got);
    if (exp_v !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_v, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    grouped_word_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (grouped_words.size() == 0) begin
        $display("%0t: word with nothing expected, expected none got %h", $time, m_axis_tdata);
        errors++;
      end else begin
        w = grouped_words.pop_front();
        check_field("out_time", 64'(w.t), 64'(m_axis_tdata[TIME_BITS-1:0]));
        check_field("out_energy", 64'(w.e), 64'(m_axis_tdata[TIME_BITS +: ENERGY_BITS]));
        check_field("out_channel", 64'(w.ch),
                    64'(m_axis_tdata[TIME_BITS+ENERGY_BITS +: CHAN_BITS]));
        check_field("group_number", 64'(w.grp),
                    64'(m_axis_tdata[TIME_BITS+ENERGY_BITS+CHAN_BITS +: GROUP_BITS]));
        check_field("last_of_group", 64'(w.last), 64'(m_axis_tlast));
        check_field("overflow_seen", 64'(w.ovf), 64'(m_axis_tuser));
      end
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  initial begin
    entry_t h;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_WINDOW_LENGTH;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    errors = 0;
    calm = 1'b0;
    long_hold = 1'b0;
    tx_gap_pct = 20;
    rx_stall_pct = 20;
    win_head = 0;
    win_fill = 0;
    next_group = '0;
    ovf_sticky = 1'b0;
    cfg_window = '0;
    cfg_majority = MAJORITY_RESET;
    cfg_mask = '1;

    // defaults after reset: zero window, majority of two
    add_hit('0, '0, '0);
    add_hit('0, '1, CHAN_MAX);
    add_hit(TIME_MAX, 32'h0000_0001, 6'd21);
    // upper bits beyond each register are dropped
    add_cfg(CFG_WINDOW_LENGTH, 64'hFFFF_0000_0000_000A);
    add_cfg(CFG_MAJORITY, 64'hFFFF_FFE1);
    add_cfg(CFG_CHAN_MASK, 64'h8000_0000_0000_0001);
    add_cfg(CFG_SPARE, '0);
    // disabled channel, then an earlier hit inside the window
    add_hit(48'd50, 32'h1234_5678, 6'd5);
    add_hit(48'd50, 32'hA5A5_A5A5, 6'd0);
    add_hit(48'd45, 32'h5A5A_5A5A, CHAN_MAX);
    add_hit(48'd61, 32'h0F0F_0F0F, 6'd0);
    // majority of zero closes on any hit outside
    add_cfg(CFG_MAJORITY, '0);
    add_cfg(CFG_CHAN_MASK, '1);
    add_cfg(CFG_WINDOW_LENGTH, '0);
    add_hit(48'd5, 32'd1, 6'd9);
    add_hit(48'd6, 32'd2, 6'd10, 1, 1'b1,
            '{t: 48'd5, e: 32'd1, ch: 6'd9, grp: 32'd2, last: 1'b1, ovf: 1'b0});
    // majority beyond capacity only replaces the oldest hit
    add_cfg(CFG_MAJORITY, 64'd17);
    add_hit(48'd7, 32'd3, 6'd1);
    add_hit(48'd8, 32'd4, 6'd2);
    // full store, then a sixteen word group
    add_cfg(CFG_MAJORITY, 64'd16);
    add_cfg(CFG_WINDOW_LENGTH, 64'(TIME_MAX));
    add_hit(48'd9, 32'h8000_0000, 6'd0, 16);
    add_cfg(CFG_WINDOW_LENGTH, 64'd100);
    add_hit(48'd500, 32'd5, 6'd33);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_CFG) settle();
        write_cfg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        for (int k = 0; k < dir_rows[i].reps; k++) begin
          h = dir_rows[i].hit;
          h.hit_time = h.hit_time + TIME_BITS'(k);
          h.hit_energy = h.hit_energy + ENERGY_BITS'(k);
          h.hit_channel = h.hit_channel + CHAN_BITS'(k);
          send_hit(h, dir_rows[i].typed, dir_rows[i].word);
        end
      end
    end

    for (int p = 0; p < PHASES; p++) run_phase(p);
    settle();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
